// ----- design/dtp_pkg.sv -----
// Shared types and constants for the duration text parser.
package dtp_pkg;

  // Parse phase codes
  localparam logic [2:0] PH_LEAD    = 3'd0;
  localparam logic [2:0] PH_DIGITS  = 3'd1;
  localparam logic [2:0] PH_SUFFIX  = 3'd2;
  localparam logic [2:0] PH_NEG     = 3'd3;
  localparam logic [2:0] PH_INVALID = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_NEG     = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;
  localparam logic [2:0] ST_MISSING = 3'd5;
  localparam logic [2:0] ST_UNKNOWN = 3'd6;

  // Characters
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_S     = 8'h73;
  localparam logic [7:0] CHAR_M     = 8'h6D;
  localparam logic [7:0] CHAR_H     = 8'h68;
  localparam logic [15:0] SFX_MS    = {CHAR_S, CHAR_M};

  // Unit multipliers and the largest count each allows
  localparam int unsigned MUL_W = 22;
  localparam logic [MUL_W-1:0] MUL_MS   = 22'd1;
  localparam logic [MUL_W-1:0] MUL_SEC  = 22'd1000;
  localparam logic [MUL_W-1:0] MUL_MIN  = 22'd60000;
  localparam logic [MUL_W-1:0] MUL_HOUR = 22'd3600000;
  localparam logic [63:0] MAX_S64   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_MS    = MAX_S64;
  localparam logic [63:0] LIM_SEC   = MAX_S64 / 64'd1000;
  localparam logic [63:0] LIM_MIN   = MAX_S64 / 64'd60000;
  localparam logic [63:0] LIM_HOUR  = MAX_S64 / 64'd3600000;

  // Parser state captured at the end of a string
  typedef struct packed {
    logic [2:0]  phase;
    logic [63:0] count;
    logic        overflow;
    logic [15:0] sfx;
    logic [1:0]  sfx_len;
    logic        sfx_bad;
  } rec_t;

endpackage

// ----- design/dtp_scan.sv -----
// Character scanner: per-word update of the parse state.
module dtp_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        char_byte,
  input  logic              has_char,
  input  logic              is_last,
  output dtp_pkg::rec_t     rec
);

  logic [2:0]  phase, phase_next;
  logic [63:0] count, count_next;
  logic        ovf, ovf_next;
  logic [15:0] sfx, sfx_next;
  logic [1:0]  slen, slen_next;
  logic        sbad, sbad_next;
  logic        pend, pend_next;

  logic        blank, digit, take_sfx;
  logic [3:0]  dval;
  logic [67:0] mac;

  always_comb begin
    blank = (char_byte == dtp_pkg::CHAR_SPACE) || (char_byte == dtp_pkg::CHAR_TAB);
    digit = (char_byte >= dtp_pkg::CHAR_ZERO) && (char_byte <= dtp_pkg::CHAR_NINE);
    dval  = 4'(char_byte - dtp_pkg::CHAR_ZERO);
    // count * 10 + digit, carry above bit 63 flags overflow
    mac   = ({4'b0, count} << 3) + ({4'b0, count} << 1) + {64'b0, dval};

    phase_next = phase;
    count_next = count;
    ovf_next   = ovf;
    sfx_next   = sfx;
    slen_next  = slen;
    sbad_next  = sbad;
    pend_next  = pend;
    take_sfx   = 1'b0;

    if (has_char) begin
      unique case (phase)
        dtp_pkg::PH_LEAD: begin
          if (!blank) begin
            if (char_byte == dtp_pkg::CHAR_MINUS) begin
              phase_next = dtp_pkg::PH_NEG;
            end else if (digit) begin
              phase_next = dtp_pkg::PH_DIGITS;
              count_next = {60'b0, dval};
            end else begin
              phase_next = dtp_pkg::PH_INVALID;
            end
          end
        end
        dtp_pkg::PH_DIGITS: begin
          if (digit) begin
            if (mac[67:64] != 4'b0) begin
              ovf_next = 1'b1;
            end
            count_next = mac[63:0];
          end else begin
            phase_next = dtp_pkg::PH_SUFFIX;
            take_sfx   = 1'b1;
          end
        end
        dtp_pkg::PH_SUFFIX: begin
          take_sfx = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // suffix: blanks are held back; one followed by more text spoils the unit
    if (take_sfx) begin
      if (blank) begin
        pend_next = 1'b1;
      end else begin
        if (pend) begin
          sbad_next = 1'b1;
        end
        if (slen == 2'd0) begin
          sfx_next  = {8'b0, char_byte};
          slen_next = 2'd1;
        end else if (slen == 2'd1) begin
          sfx_next  = {char_byte, sfx[7:0]};
          slen_next = 2'd2;
        end else begin
          sbad_next = 1'b1;
        end
      end
    end

    rec.phase    = phase_next;
    rec.count    = count_next;
    rec.overflow = ovf_next;
    rec.sfx      = sfx_next;
    rec.sfx_len  = slen_next;
    rec.sfx_bad  = sbad_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && is_last)) begin
      phase <= dtp_pkg::PH_LEAD;
      count <= 64'b0;
      ovf   <= 1'b0;
      sfx   <= 16'b0;
      slen  <= 2'b0;
      sbad  <= 1'b0;
      pend  <= 1'b0;
    end else if (take) begin
      phase <= phase_next;
      count <= count_next;
      ovf   <= ovf_next;
      sfx   <= sfx_next;
      slen  <= slen_next;
      sbad  <= sbad_next;
      pend  <= pend_next;
    end
  end

endmodule

// ----- design/duration_text_parser.sv -----
// Top level of the duration text parser: scanner, finish decode and scaling pipeline.
//
//   channel   dir   words                         payload
//   s_axis    in    one text character per word   tdata: char_byte; tuser: has_char;
//                                                  tlast: is_last
//   m_axis    out   one result per string          tdata: duration_ms, status
//
// One input word is taken every cycle while s_axis_tready is high; the parse state updates
// in the cycle it is accepted. A result leaves through registered stages after the word marked
// last: record capture, status decode with split 32x22 partial products, then the final add.
// Each stage moves on whenever the stage after it can take a word; s_axis_tready drops
// only while stage B holds a record that cannot move, so input keeps flowing until
// three results are queued behind a stalled m_axis.
// rst is synchronous and active high; it empties the pipe and restarts the parse.
module duration_text_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tuser,   // [0] has_char
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // [62:0] duration_ms, [65:63] status, [71:66] zero
);

  logic          s_acc;
  dtp_pkg::rec_t scan_rec;

  // stage B: captured end-of-string record
  logic          b_valid;
  dtp_pkg::rec_t b_rec;
  logic          b_ready;

  // stage C: status and partial products
  logic          c_valid;
  logic [2:0]    c_status;
  logic [53:0]   c_pp_lo;
  logic [53:0]   c_pp_hi;
  logic          c_ready;

  // stage D: output word
  logic          d_valid;
  logic [2:0]    d_status;
  logic [62:0]   d_ms;
  logic          d_ready;

  logic [2:0]            b_status;
  logic [dtp_pkg::MUL_W-1:0] b_mul;
  logic [dtp_pkg::MUL_W-1:0] b_unit;
  logic [63:0]           b_limit;
  logic [63:0]           c_sum;

  assign d_ready       = !d_valid || m_axis_tready;
  assign c_ready       = !c_valid || d_ready;
  assign b_ready       = !b_valid || c_ready;
  assign s_axis_tready = b_ready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  dtp_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .take      (s_acc),
    .char_byte (s_axis_tdata),
    .has_char  (s_axis_tuser),
    .is_last   (s_axis_tlast),
    .rec       (scan_rec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= s_acc && s_axis_tlast;
    end
    if (b_ready && s_acc && s_axis_tlast) begin
      b_rec <= scan_rec;
    end
  end

  // unit lookup: "ms" needs both bytes, single letters leave the high byte zero
  always_comb begin
    b_unit  = '0;
    b_limit = dtp_pkg::LIM_MS;
    if (b_rec.sfx_len == 2'd2) begin
      if (b_rec.sfx == dtp_pkg::SFX_MS) begin
        b_unit  = dtp_pkg::MUL_MS;
        b_limit = dtp_pkg::LIM_MS;
      end
    end else if (b_rec.sfx_len == 2'd1) begin
      unique case (b_rec.sfx[7:0])
        dtp_pkg::CHAR_S: begin
          b_unit  = dtp_pkg::MUL_SEC;
          b_limit = dtp_pkg::LIM_SEC;
        end
        dtp_pkg::CHAR_M: begin
          b_unit  = dtp_pkg::MUL_MIN;
          b_limit = dtp_pkg::LIM_MIN;
        end
        dtp_pkg::CHAR_H: begin
          b_unit  = dtp_pkg::MUL_HOUR;
          b_limit = dtp_pkg::LIM_HOUR;
        end
        default: begin
        end
      endcase
    end
  end

  // error priority follows the phase, then overflow, then suffix checks, then the unit limit
  always_comb begin
    unique case (b_rec.phase) inside
      dtp_pkg::PH_LEAD:   b_status = dtp_pkg::ST_EMPTY;
      dtp_pkg::PH_NEG:    b_status = dtp_pkg::ST_NEG;
      dtp_pkg::PH_DIGITS,
      dtp_pkg::PH_SUFFIX: begin
        if (b_rec.overflow) begin
          b_status = dtp_pkg::ST_RANGE;
        end else if (b_rec.sfx_bad) begin
          b_status = dtp_pkg::ST_UNKNOWN;
        end else if (b_rec.sfx_len == 2'd0) begin
          b_status = dtp_pkg::ST_MISSING;
        end else if (b_unit == '0) begin
          b_status = dtp_pkg::ST_UNKNOWN;
        end else if (b_rec.count > b_limit) begin
          b_status = dtp_pkg::ST_RANGE;
        end else begin
          b_status = dtp_pkg::ST_OK;
        end
      end
      default:            b_status = dtp_pkg::ST_INVALID;
    endcase
    // zero multiplier on any error gives a zero duration for free
    b_mul = (b_status == dtp_pkg::ST_OK) ? b_unit : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
    if (c_ready && b_valid) begin
      c_status <= b_status;
      c_pp_lo  <= b_rec.count[31:0] * b_mul;
      c_pp_hi  <= b_rec.count[63:32] * b_mul;
    end
  end

  // a valid product is below 2^63, so the high partial product fits in 31 bits
  assign c_sum = {10'b0, c_pp_lo} + {c_pp_hi[31:0], 32'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (d_ready) begin
      d_valid <= c_valid;
    end
    if (d_ready && c_valid) begin
      d_status <= c_status;
      d_ms     <= c_sum[62:0];
    end
  end

  assign m_axis_tvalid = d_valid;
  assign m_axis_tdata  = {6'b0, d_status, d_ms};

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[65:63] != dtp_pkg::ST_OK)) |-> (m_axis_tdata[62:0] == 63'b0))
    else $error("nonzero duration with error status");

  a_rec_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(b_valid) |-> $past(s_acc && s_axis_tlast))
    else $error("record captured without a last word");

  a_b_hold: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !c_ready) |=> (b_valid && $stable(b_rec)))
    else $error("stalled record lost or changed");

  a_c_hold: assert property (@(posedge clk) disable iff (rst)
    (c_valid && !d_ready) |=> (c_valid && $stable(c_status) && $stable(c_pp_lo)))
    else $error("stalled product lost or changed");
`endif

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for duration_text_parser: directed, boundary and random strings.
`timescale 1ns / 100ps

module tb;

  localparam logic [63:0] S64_TOP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned STUCK_LIMIT = 4000;
  localparam int unsigned RANDOM_WORDS = 1000;

  typedef struct packed {
    logic [62:0] ms;
    logic [2:0]  status;
  } duration_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] char_byte
  logic        s_axis_tuser = 1'b0;    // [0] has_char
  logic        s_axis_tlast = 1'b0;    // is_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;           // [62:0] duration_ms, [65:63] status

  always #4 clk = ~clk;

  duration_text_parser dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Unit table: suffix text and its scale to milliseconds
  string       unit_txt[4]   = '{"ms", "s", "m", "h"};
  logic [63:0] unit_scale[4] = '{64'd1, 64'd1000, 64'd60000, 64'd3600000};

  // Parser state mirrored on the testbench side
  logic [2:0]  p_phase = dtp_pkg::PH_LEAD;
  logic [63:0] p_count = '0;
  logic        p_ovf = 1'b0;
  logic [15:0] p_sfx = '0;
  logic [1:0]  p_sfx_len = '0;
  logic        p_sfx_bad = 1'b0;
  logic        p_gap = 1'b0;

  duration_t   duration_q[$];
  logic [7:0]  text_buf[$];

  int unsigned items_sent = 0;
  int unsigned strings_sent = 0;
  int unsigned results_seen = 0;
  int unsigned failures = 0;
  int unsigned status_seen[8] = '{default: 0};
  int unsigned burst_left = 0;
  int unsigned stuck_cycles = 0;
  logic [31:0] rx_cycle = '0;

  function automatic logic is_blank(input logic [7:0] c);
    return c == dtp_pkg::CHAR_SPACE || c == dtp_pkg::CHAR_TAB;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= dtp_pkg::CHAR_ZERO && c <= dtp_pkg::CHAR_NINE;
  endfunction

  // Suffix collection: a blank followed by anything else, or a third char, spoils it
  task automatic suffix_char(input logic [7:0] c);
    if (is_blank(c)) begin
      p_gap = 1'b1;
    end else begin
      if (p_gap) p_sfx_bad = 1'b1;
      if (p_sfx_len == 2'd0) begin
        p_sfx[7:0] = c;
        p_sfx_len = 2'd1;
      end else if (p_sfx_len == 2'd1) begin
        p_sfx[15:8] = c;
        p_sfx_len = 2'd2;
      end else begin
        p_sfx_bad = 1'b1;
      end
    end
  endtask

  task automatic scan_char(input logic [7:0] c);
    logic [63:0] d;
    d = {56'd0, c - dtp_pkg::CHAR_ZERO};
    case (p_phase)
      dtp_pkg::PH_LEAD: begin
        if (!is_blank(c)) begin
          if (c == dtp_pkg::CHAR_MINUS) p_phase = dtp_pkg::PH_NEG;
          else if (is_digit(c)) begin
            p_phase = dtp_pkg::PH_DIGITS;
            p_count = d;
          end else p_phase = dtp_pkg::PH_INVALID;
        end
      end
      dtp_pkg::PH_DIGITS: begin
        if (is_digit(c)) begin
          if (p_count > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) p_ovf = 1'b1;
          p_count = p_count * 64'd10 + d;
        end else begin
          p_phase = dtp_pkg::PH_SUFFIX;
          suffix_char(c);
        end
      end
      dtp_pkg::PH_SUFFIX: suffix_char(c);
      default: ;
    endcase
  endtask

  // End of string: decide the status and value, queue it, start afresh
  task automatic close_string();
    duration_t   r;
    logic [63:0] scale;
    logic [63:0] prod;
    r.ms = '0;
    scale = '0;
    if (p_phase == dtp_pkg::PH_LEAD) r.status = dtp_pkg::ST_EMPTY;
    else if (p_phase == dtp_pkg::PH_NEG) r.status = dtp_pkg::ST_NEG;
    else if (p_phase != dtp_pkg::PH_DIGITS && p_phase != dtp_pkg::PH_SUFFIX)
      r.status = dtp_pkg::ST_INVALID;
    else if (p_ovf) r.status = dtp_pkg::ST_RANGE;
    else if (p_sfx_bad) r.status = dtp_pkg::ST_UNKNOWN;
    else if (p_sfx_len == 2'd0) r.status = dtp_pkg::ST_MISSING;
    else begin
      if (p_sfx_len == 2'd2) begin
        if (p_sfx == {dtp_pkg::CHAR_S, dtp_pkg::CHAR_M}) scale = unit_scale[0];
      end else begin
        case (p_sfx[7:0])
          dtp_pkg::CHAR_S: scale = unit_scale[1];
          dtp_pkg::CHAR_M: scale = unit_scale[2];
          dtp_pkg::CHAR_H: scale = unit_scale[3];
          default: ;
        endcase
      end
      if (scale == 64'd0) r.status = dtp_pkg::ST_UNKNOWN;
      else if (p_count > S64_TOP / scale) r.status = dtp_pkg::ST_RANGE;
      else begin
        prod = p_count * scale;
        r.ms = prod[62:0];
        r.status = dtp_pkg::ST_OK;
      end
    end
    duration_q.push_back(r);
    p_phase = dtp_pkg::PH_LEAD;
    p_count = '0;
    p_ovf = 1'b0;
    p_sfx = '0;
    p_sfx_len = '0;
    p_sfx_bad = 1'b0;
    p_gap = 1'b0;
  endtask

  // One word on s_axis; called at a falling edge, returns at one.
  // The sender runs in bursts; a gap follows each burst.
  task automatic send_item(input logic [7:0] ch, input logic has, input logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= has;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (has) scan_char(ch);
    if (last) close_string();
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  // Send text_buf as one string. The end mark rides on the last char, or on a
  // separate word with no char. Empty words may be sprinkled in between.
  task automatic send_text(input bit hole_end, input bit holes);
    int n;
    n = text_buf.size();
    for (int i = 0; i < n; i++) begin
      if (holes && $urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(text_buf[i], 1'b1, !hole_end && i == n - 1);
    end
    if (hole_end || n == 0) send_item(8'($urandom), 1'b0, 1'b1);
    text_buf.delete();
    strings_sent++;
  endtask

  // Hold the sender off until every queued result has come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (duration_q.size() != 0);
  endtask

  // A decimal count for unit u: mostly small, some wide, some at the range edge
  task automatic add_count(input int u);
    logic [63:0] v;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) v = 64'($urandom_range(0, 99999));
    else if (sel < 70) v = {$urandom, $urandom} >> $urandom_range(0, 63);
    else v = S64_TOP / unit_scale[u] - 64'd2 + 64'($urandom_range(0, 4));
    if ($urandom_range(0, 9) == 0) add_text("00");
    if (sel < 90) begin
      add_text($sformatf("%0d", v));
    end else begin
      // 19 to 22 digits: the count often passes 64 bits
      repeat ($urandom_range(19, 22))
        text_buf.push_back(dtp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic add_blanks(input int most);
    repeat ($urandom_range(0, most))
      text_buf.push_back($urandom_range(0, 1) ? dtp_pkg::CHAR_SPACE : dtp_pkg::CHAR_TAB);
  endtask

  task automatic test_directed();
    text_buf.delete();
    send_text(1'b1, 1'b0);                        // nothing at all
    add_text(" \t");  send_text(1'b0, 1'b0);      // blanks only
    add_text("0ms");  send_text(1'b0, 1'b0);
    add_text("1s");   send_text(1'b0, 1'b0);
    add_text("7m");   send_text(1'b1, 1'b0);
    add_text("3h");   send_text(1'b0, 1'b0);
    add_text("\t42s "); send_text(1'b0, 1'b0);    // trimmed at both ends
    add_text("-5s");  send_text(1'b0, 1'b0);
    add_text("x9");   send_text(1'b0, 1'b0);
    add_text("12");   send_text(1'b0, 1'b0);      // no unit
    add_text("12 ");  send_text(1'b0, 1'b0);      // trailing blank, still no unit
    add_text("4 s");  send_text(1'b0, 1'b0);      // blank inside the suffix
    add_text("9sm");  send_text(1'b0, 1'b0);
    add_text("9mss"); send_text(1'b0, 1'b0);      // suffix too long
    add_text("8H");   send_text(1'b0, 1'b0);
    add_text("5");    text_buf.push_back(8'h00); send_text(1'b0, 1'b0);  // NUL as a unit
    // empty word in the middle of a string leaves it intact
    send_item(8'h31, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(dtp_pkg::CHAR_S, 1'b1, 1'b1);
    strings_sent++;
  endtask

  task automatic test_limits();
    logic [63:0] lim;
    for (int u = 0; u < 4; u++) begin
      lim = S64_TOP / unit_scale[u];
      add_text($sformatf("%0d", lim));
      add_text(unit_txt[u]);
      send_text(1'b0, 1'b0);
      add_text($sformatf("%0d", lim + 64'd1));
      add_text(unit_txt[u]);
      send_text(1'b1, 1'b0);
    end
    add_text("18446744073709551615ms"); send_text(1'b0, 1'b0);   // fits 64 bits, too big
    add_text("18446744073709551616s");  send_text(1'b0, 1'b0);   // count overflow
    add_text("99999999999999999999 xx"); send_text(1'b0, 1'b0); // overflow wins over unit
    add_text("0000000000000000000000007h"); send_text(1'b0, 1'b0);
  endtask

  task automatic test_random();
    int unsigned start;
    int kind;
    int u;
    start = items_sent;
    while (items_sent - start < RANDOM_WORDS) begin
      kind = $urandom_range(0, 99);
      u = $urandom_range(0, 3);
      if (kind < 85) begin
        add_blanks(2);
        add_count(u);
        if (kind < 70) begin
          add_text(unit_txt[u]);
        end else begin
          case ($urandom_range(0, 5))
            0: ;
            1: begin
              add_blanks(1);
              text_buf.push_back(dtp_pkg::CHAR_SPACE);
              add_text(unit_txt[u]);
            end
            2: begin add_text(unit_txt[u]); text_buf.push_back(8'($urandom)); end
            3: repeat ($urandom_range(1, 2)) text_buf.push_back(8'($urandom));
            4: begin
              if (u == 0) add_text("MS");
              else add_text("S");
            end
            default: add_text("sm");
          endcase
        end
        add_blanks(2);
      end else begin
        // noise drawn from bytes that matter to the parser and from the whole range
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 7)) inside
            [0:3]: text_buf.push_back(8'($urandom));
            4: text_buf.push_back(dtp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            5: text_buf.push_back(dtp_pkg::CHAR_TAB);
            6: text_buf.push_back(dtp_pkg::CHAR_MINUS);
            default: text_buf.push_back($urandom_range(0, 1) ? dtp_pkg::CHAR_M
                                                             : dtp_pkg::CHAR_H);
          endcase
        end
      end
      send_text($urandom_range(0, 6) == 0, $urandom_range(0, 4) == 0);
      if ($urandom_range(0, 149) == 0) drain_results();
    end
  endtask

  // Receiver: four stall patterns, taken in turn as rx_cycle[8:7] counts up
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 32'd1;
    case (rx_cycle[8:7])
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2:    m_axis_tready <= (rx_cycle[2:0] == 3'd0);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic void note_failure(input string what, input duration_t want,
                                       input duration_t got);
    failures++;
    if (failures <= 10)
      $display("[%0t] %s: expected ms=%0d status=%0d, got ms=%0d status=%0d",
               $realtime, what, want.ms, want.status, got.ms, got.status);
  endfunction

  always @(posedge clk) begin : check_result
    duration_t got;
    duration_t want;
    got.ms = m_axis_tdata[62:0];
    got.status = m_axis_tdata[65:63];
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      status_seen[got.status]++;
      if (duration_q.size() == 0) begin
        note_failure("unexpected result", '0, got);
      end else begin
        want = duration_q.pop_front();
        if (got.ms !== want.ms || got.status !== want.status)
          note_failure("result mismatch", want, got);
      end
    end
  end

  // Watchdog: too long with no word moving on either side ends the run
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d results outstanding",
               stuck_cycles, duration_q.size());
      $display("duration_text_parser verification failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    drain_results();
    test_limits();
    drain_results();
    test_random();
    drain_results();
    // pipeline is three deep; leave room for any stray result
    repeat (8) @(posedge clk);
    $display("covered %0d strings in %0d words, %0d results checked, %0d failures",
             strings_sent, items_sent, results_seen, failures);
    $display("status mix: ok %0d empty %0d neg %0d range %0d invalid %0d missing %0d unknown %0d",
             status_seen[dtp_pkg::ST_OK], status_seen[dtp_pkg::ST_EMPTY],
             status_seen[dtp_pkg::ST_NEG], status_seen[dtp_pkg::ST_RANGE],
             status_seen[dtp_pkg::ST_INVALID], status_seen[dtp_pkg::ST_MISSING],
             status_seen[dtp_pkg::ST_UNKNOWN]);
    if (failures == 0 && duration_q.size() == 0)
      $display("duration_text_parser verification clean");
    else
      $display("duration_text_parser verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
design/dtp_pkg.sv
design/dtp_scan.sv
design/duration_text_parser.sv
test/tb.sv
